// File: rtl/core/rrl_pkg.sv
// shared types and constants for the request rate limiter
package rrl_pkg;

    localparam int TS_W          = 31;
    localparam int MAXREQ_W      = 7;
    localparam int LOG_DEPTH_DEF = 64;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam int REG_IDX_W     = 2;

    localparam logic [REG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAXREQ  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LEN = 2'd2;

    localparam logic MODE_FIXED   = 1'b0;
    localparam logic MODE_SLIDING = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_POP_RD,
        ST_POP_CHK,
        ST_LOG,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fix_upd;
        logic pop;
        logic log_upd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic div_last;
        logic fill_zero;
        logic pop_ok;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/request_rate_limiter_core.sv
// fixed window mode: the timestamp is loaded, divided by the window length in the 31-step
// divider and counted in the window counter; the result enters the output register once it is free
// sliding log mode: expired head entries are read and popped one at a time, an allowed request
// is logged, then the result enters the output register once it is free
// one request in flight; the next is taken the cycle after its result enters the output register
// synchronous active-low reset clears control, registers and log pointers; log memory is not cleared
module request_rate_limiter_core
    import rrl_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [TS_W-1:0]       i_timestamp,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_allowed,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic                 r_mode;
    logic [MAXREQ_W-1:0]  r_max_req;
    logic [TS_W-1:0]      r_win_len;
    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_reg_idx;
    t_cmd                 w_cmd;
    t_stat                w_stat;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[REG_IDX_W+1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_FIXED;
            r_max_req <= '0;
            r_win_len <= TS_W'(1);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_MODE:    r_mode    <= pwdata[0];
                REG_MAXREQ:  r_max_req <= pwdata[MAXREQ_W-1:0];
                REG_WIN_LEN: r_win_len <= pwdata[TS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_MODE:    prdata = APB_DATA_W'(r_mode);
            REG_MAXREQ:  prdata = APB_DATA_W'(r_max_req);
            REG_WIN_LEN: prdata = APB_DATA_W'(r_win_len);
            default:     prdata = '0;
        endcase
    end

    rrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rrl_dp #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_mode          (r_mode),
        .i_max_requests  (r_max_req),
        .i_window_length (r_win_len),
        .i_timestamp     (i_timestamp),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_allowed       (o_allowed)
    );

    // a taken request blocks the input until its result is stored
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting a transaction");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> !w_stat.fill_zero)
        else $error("pop issued on an empty log");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result loaded over an untaken result");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_valid && !o_stall)
        else $error("loaded result not presented");

endmodule

// File: rtl/core/rrl_div.sv
// restoring divider, one quotient bit per cycle while i_step is high
module rrl_div
    import rrl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_step,
    input  logic [TS_W-1:0] i_dividend,
    input  logic [TS_W-1:0] i_divisor,
    output logic            o_last,
    output logic [TS_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(TS_W);

    logic [TS_W-1:0]  r_rem;
    logic [TS_W-1:0]  r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [TS_W+1:0]  w_trial;

    // partial remainder stays below the divisor, so two guard bits suffice
    assign w_trial = {1'b0, r_rem, r_quo[TS_W-1]} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (i_step) begin
            if (!w_trial[TS_W+1]) begin
                r_rem <= w_trial[TS_W-1:0];
            end else begin
                r_rem <= {r_rem[TS_W-2:0], r_quo[TS_W-1]};
            end
            r_quo <= {r_quo[TS_W-2:0], ~w_trial[TS_W+1]};
        end
    end

    assign o_last     = (r_cnt == CNT_W'(TS_W - 1));
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/rrl_dp.sv
// limiter datapath: divider, window counter, timestamp log, result register
module rrl_dp
    import rrl_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_mode,
    input  logic [MAXREQ_W-1:0] i_max_requests,
    input  logic [TS_W-1:0]     i_window_length,
    input  logic [TS_W-1:0]     i_timestamp,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_allowed
);

    localparam int PTR_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int FILL_W = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > MAXREQ_W) ? FILL_W : MAXREQ_W;

    logic [TS_W-1:0]     r_ts;
    logic [TS_W-1:0]     w_len;
    logic [TS_W-1:0]     w_quo;
    logic                w_div_last;

    logic [TS_W-1:0]     r_win_idx;
    logic [MAXREQ_W-1:0] r_win_cnt;
    logic [MAXREQ_W-1:0] w_cnt_base;
    logic                w_fix_ok;

    logic [TS_W-1:0]     r_log [LOG_DEPTH];
    logic [TS_W-1:0]     r_rd;
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    r_tail;
    logic [FILL_W-1:0]   r_fill;
    logic [CMP_W-1:0]    w_limit;
    logic                w_log_ok;

    logic                r_allowed;
    logic                r_out_valid;
    logic                r_out_allowed;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LOG_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign w_len = (i_window_length == '0) ? TS_W'(1) : i_window_length;

    rrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_step     (i_cmd.div_step),
        .i_dividend (i_timestamp),
        .i_divisor  (w_len),
        .o_last     (w_div_last),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ts <= i_timestamp;
        end
    end

    // fixed window: a new index restarts the count
    assign w_cnt_base = (w_quo != r_win_idx) ? '0 : r_win_cnt;
    assign w_fix_ok   = (w_cnt_base < i_max_requests);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_idx <= '0;
            r_win_cnt <= '0;
        end else if (i_cmd.fix_upd) begin
            r_win_idx <= w_quo;
            r_win_cnt <= w_fix_ok ? w_cnt_base + MAXREQ_W'(1) : w_cnt_base;
        end
    end

    // sliding log: limit saturates at the log depth
    assign w_limit  = (CMP_W'(i_max_requests) > CMP_W'(LOG_DEPTH)) ?
                      CMP_W'(LOG_DEPTH) : CMP_W'(i_max_requests);
    assign w_log_ok = (CMP_W'(r_fill) < w_limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.log_upd && w_log_ok) begin
            r_log[r_tail] <= r_ts;
        end
        r_rd <= r_log[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.pop) begin
            r_head <= next_ptr(r_head);
            r_fill <= r_fill - FILL_W'(1);
        end else if (i_cmd.log_upd && w_log_ok) begin
            r_tail <= next_ptr(r_tail);
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix_upd) begin
            r_allowed <= w_fix_ok;
        end else if (i_cmd.log_upd) begin
            r_allowed <= w_log_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_allowed <= r_allowed;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_allowed = r_out_allowed;

    always_comb begin
        o_stat.mode      = i_mode;
        o_stat.div_last  = w_div_last;
        o_stat.fill_zero = (r_fill == '0);
        // oldest + len - 1 < ts, taken one bit wider so it never wraps
        o_stat.pop_ok    = (({1'b0, r_rd} + {1'b0, w_len}) <= {1'b0, r_ts});
        o_stat.out_free  = !r_out_valid || !i_stall;
    end

endmodule

// File: rtl/core/rrl_ctrl.sv
// limiter controller state machine
module rrl_ctrl
    import rrl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_stat.mode == MODE_SLIDING) ? ST_POP_RD : ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.fix_upd = 1'b1;
                n_state       = ST_DONE;
            end
            ST_POP_RD: begin
                // head entry is read this cycle, compared next
                n_state = i_stat.fill_zero ? ST_LOG : ST_POP_CHK;
            end
            ST_POP_CHK: begin
                if (i_stat.pop_ok) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_POP_RD;
                end else begin
                    n_state = ST_LOG;
                end
            end
            ST_LOG: begin
                o_cmd.log_upd = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

// File: sim/tb_request_rate_limiter_core.sv
// testbench for the request rate limiter core: directed and random requests in both modes
`timescale 1ns / 100ps

module tb_request_rate_limiter_core
    import rrl_pkg::*;
();

    localparam int LOG_DEPTH  = LOG_DEPTH_DEF;
    localparam int HOLD_LONG  = 400;
    localparam int DRAIN_GAP  = 150;
    localparam int PHASE_REQS = 300;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [TS_W-1:0]       i_timestamp = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic                  o_allowed;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    request_rate_limiter_core #(.LOG_DEPTH(LOG_DEPTH)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_timestamp(i_timestamp),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_allowed  (o_allowed),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow registers and limiter state
    logic                cfg_mode = MODE_FIXED;
    logic [MAXREQ_W-1:0] cfg_max  = '0;
    logic [TS_W-1:0]     cfg_len  = TS_W'(1);
    logic [TS_W-1:0]     win_index = '0;
    logic [MAXREQ_W-1:0] win_count = '0;
    logic [TS_W-1:0]     req_log [LOG_DEPTH];
    logic [5:0]          log_head = '0;
    logic [5:0]          log_tail = '0;
    logic [6:0]          log_fill = '0;

    bit allow_expected [$];

    int err_cnt    = 0;
    int n_requests = 0;
    int n_allowed  = 0;
    int n_writes   = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    function automatic bit predict_allowed(input logic [TS_W-1:0] ts);
        logic [TS_W-1:0]     eff;
        logic [6:0]          lim;
        logic [31:0]         span_end;
        bit                  ok;
        eff = (cfg_len == '0) ? TS_W'(1) : cfg_len;
        ok  = 1'b0;
        if (cfg_mode == MODE_FIXED) begin
            if (ts / eff != win_index) begin
                win_index = ts / eff;
                win_count = '0;
            end
            if (win_count < cfg_max) begin
                win_count = win_count + 1'b1;
                ok = 1'b1;
            end
        end else begin
            lim = (cfg_max > 7'(LOG_DEPTH)) ? 7'(LOG_DEPTH) : cfg_max;
            // wide compare, oldest + len never wraps
            while (log_fill != 0) begin
                span_end = {1'b0, req_log[log_head]} + {1'b0, eff};
                if (span_end < {1'b0, ts} + 32'd1) begin
                    log_head = log_head + 1'b1;
                    log_fill = log_fill - 1'b1;
                end else begin
                    break;
                end
            end
            if (log_fill < lim) begin
                req_log[log_tail] = ts;
                log_tail = log_tail + 1'b1;
                log_fill = log_fill + 1'b1;
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

    // result side: check each transaction and drive stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (allow_expected.size() == 0) begin
                    $error("unexpected result: allowed=%0d", o_allowed);
                    err_cnt++;
                end else begin
                    if (o_allowed !== allow_expected[0]) begin
                        $error("allowed mismatch: expected %0d, actual %0d",
                               allow_expected[0], o_allowed);
                        err_cnt++;
                    end
                    void'(allow_expected.pop_front());
                end
            end
        end
        if (hold_req) begin
            hold_left = HOLD_LONG;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // leaves i_valid high; the caller lowers it or sends again in the same step
    task automatic send_request(input logic [TS_W-1:0] ts);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        allow_expected.push_back(predict_allowed(ts));
        if (allow_expected[$]) n_allowed++;
        n_requests++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (allow_expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:    cfg_mode = value[0];
            REG_MAXREQ:  cfg_max  = value[MAXREQ_W-1:0];
            REG_WIN_LEN: cfg_len  = value[TS_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic test_reset_state();
        // limit of zero after reset denies everything
        send_request('0);
        send_request('1);
        wait_idle();
    endtask

    task automatic test_fixed_window();
        write_reg(REG_MAXREQ, 32'd2);
        write_reg(REG_WIN_LEN, 32'd0);   // zero length acts as one
        send_request(TS_W'(5));
        send_request(TS_W'(5));
        send_request(TS_W'(5));
        send_request(TS_W'(6));
        write_reg(REG_WIN_LEN, 32'h7FFF_FFFF);
        send_request('0);
        send_request(TS_W'(31'h7FFF_FFFE));
        send_request(TS_W'(31'h7FFF_FFFF));
        write_reg(REG_MAXREQ, 32'd127);  // used as is in this mode
        send_request(TS_W'(31'h7FFF_FFFF));
        wait_idle();
    endtask

    task automatic test_sliding_log();
        write_reg(REG_MODE, 32'(MODE_SLIDING));
        write_reg(REG_MAXREQ, 32'd127);  // saturates to log depth
        send_request(TS_W'(31'h7FFF_FFF0));
        send_request(TS_W'(31'h7FFF_FFFF));  // oldest + length above 31 bits
        write_reg(REG_WIN_LEN, 32'd1);
        send_request(TS_W'(31'h7FFF_FFFF));
        write_reg(REG_MAXREQ, 32'd0);
        send_request(TS_W'(31'h7FFF_FFFF));
        write_reg(REG_MAXREQ, 32'd64);
        write_reg(REG_WIN_LEN, 32'd0);
        send_request(TS_W'(100));
        send_request(TS_W'(100));
        wait_idle();
    endtask

    task automatic test_mode_switch();
        // each mode keeps its own state across switches
        write_reg(REG_MODE, 32'(MODE_FIXED));
        write_reg(REG_MAXREQ, 32'd1);
        send_request(TS_W'(31'h7FFF_FFFF));
        write_reg(REG_MODE, 32'(MODE_SLIDING));
        send_request(TS_W'(100));
        write_reg(REG_MODE, 32'(MODE_FIXED));
        send_request(TS_W'(31'h7FFF_FFFF));
        wait_idle();
    endtask

    task automatic run_random_block(output int sent);
        logic [TS_W-1:0] base;
        logic [TS_W-1:0] len;
        logic [6:0]      mx;
        int              r;
        int              step_max;
        int              cnt;
        r = $urandom_range(99);
        if (r < 10)      mx = 7'd0;
        else if (r < 16) mx = 7'd64;
        else if (r < 20) mx = 7'($urandom_range(65, 127));
        else             mx = 7'($urandom_range(1, 8));
        r = $urandom_range(99);
        if (r < 8)       len = '0;
        else if (r < 12) len = TS_W'(31'h7FFF_FFFF);
        else if (r < 16) len = TS_W'($urandom);
        else             len = TS_W'($urandom_range(1, 40));
        write_reg(REG_MODE, 32'($urandom_range(1)));
        write_reg(REG_MAXREQ, 32'(mx));
        write_reg(REG_WIN_LEN, 32'(len));
        step_max = (len == '0) ? 2 : ((len > 64) ? 1000 : 2 * int'(len));
        base = TS_W'($urandom);
        cnt  = $urandom_range(15, 40);
        for (int k = 0; k < cnt; k++) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_request(TS_W'($urandom));   // out-of-order noise
            end else begin
                if (r < 16) base = base + TS_W'($urandom);
                else        base = base + TS_W'($urandom_range(0, step_max));
                send_request(base);
            end
        end
        sent = cnt;
    endtask

    task automatic test_random_phase(input int snd_pct, input int rcv_pct);
        int total;
        int sent;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        total = 0;
        while (total < PHASE_REQS) begin
            run_random_block(sent);
            total += sent;
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(REG_MODE, 32'(MODE_FIXED));
        write_reg(REG_MAXREQ, 32'd3);
        write_reg(REG_WIN_LEN, 32'd4);
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) send_request(TS_W'(k));
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_fixed_window();
        test_sliding_log();
        test_mode_switch();
        test_output_backpressure();
        test_random_phase(38, 67);
        test_random_phase(67, 38);
        test_random_phase(0, 0);
        wait_idle();
        repeat (DRAIN_GAP) @(posedge i_clk);
        if (allow_expected.size() != 0) begin
            $error("%0d results never arrived", allow_expected.size());
            err_cnt++;
        end
        $display("covered %0d requests (%0d allowed) over %0d register writes,",
                 n_requests, n_allowed, n_writes);
        $display("fixed window and sliding log modes, limit and length extremes, backpressure");
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
rtl/core/rrl_pkg.sv
rtl/core/rrl_div.sv
rtl/core/rrl_dp.sv
rtl/core/rrl_ctrl.sv
rtl/core/request_rate_limiter_core.sv
sim/tb_request_rate_limiter_core.sv
